// File: sv/sdlcfb_pkg.sv
// Shared types, constants and the CRC-16 byte update for the SDLC U-frame builder.
package sdlcfb_pkg;

  localparam int TX_FIFO_BYTES = 1024;

  localparam int          CNT_W     = 11;
  localparam logic [10:0] CNT_MAX   = 11'h7FF;
  localparam logic [10:0] OVL_LIMIT = CNT_W'(TX_FIFO_BYTES - 2);

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;

  localparam logic [7:0] ADDR_RESET = 8'h14;
  localparam logic [7:0] CTRL_RESET = 8'h83;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int   CFG_IDX_W           = 1;
  localparam logic CFG_STATION_ADDRESS = 1'b0;
  localparam logic CFG_CONTROL_BYTE    = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] station_address;
    logic [7:0] control_byte;
    logic       first;
    logic       last;
    logic       overlength;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/sdlcfb_if.sv
// Valid/ready channel interfaces for payload items and frame bytes.
interface sdlcfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface sdlcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;
  logic       overlength;

  modport source (output valid, output frame_byte, output end_of_frame, output overlength,
                  input ready);
  modport sink (input valid, input frame_byte, input end_of_frame, input overlength,
                output ready);
endinterface

// File: sv/sdlc_u_frame_builder.sv
// Top level of the SDLC U-frame builder with CRC-16/X-25 trailer.
// Each payload item goes into a four-entry queue, so a new item is taken in every
// cycle while the queue has room. The back end sends one frame byte per cycle
// through its output register while the receiver is ready: an item that opens a frame
// gives three bytes (address, control, payload), a later item one, and an item marked
// last two bytes more for the inverted CRC, so an item gives one to five bytes and
// that output register sets the sustained rate. Address and control are sampled when
// the frame's first item is accepted.
module sdlc_u_frame_builder (
  input  logic                              clk,
  input  logic                              rst_n,
  sdlcfb_in_if.sink                         in_ch,
  sdlcfb_out_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [sdlcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                        cfg_wdata
);

  logic               q_push;
  sdlcfb_pkg::entry_t q_entry;
  logic               q_full;
  logic               q_pop;
  sdlcfb_pkg::entry_t q_head;
  logic               q_head_valid;

  sdlcfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full)
  );

  sdlcfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  sdlcfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

// File: sv/sdlcfb_queue.sv
// Short FIFO of classified items between the front and back parts.
module sdlcfb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sdlcfb_pkg::entry_t  push_entry,
  output logic                full,
  input  logic                pop,
  output sdlcfb_pkg::entry_t  head,
  output logic                head_valid
);

  sdlcfb_pkg::entry_t mem_r [sdlcfb_pkg::QUEUE_DEPTH];

  logic [sdlcfb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sdlcfb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sdlcfb_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (sdlcfb_pkg::QPTR_W + 1)'(sdlcfb_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/sdlcfb_front.sv
// Front part: accepts payload items, holds the configuration and tags each item.
module sdlcfb_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  sdlcfb_in_if.sink                            in_ch,
  input  logic                                 cfg_we,
  input  logic [sdlcfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                           cfg_wdata,
  output logic                                 q_push,
  output sdlcfb_pkg::entry_t                   q_entry,
  input  logic                                 q_full
);

  logic [7:0] station_address_r;
  logic [7:0] control_byte_r;
  logic       in_frame_r, in_frame_nxt;
  logic [sdlcfb_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [sdlcfb_pkg::CNT_W-1:0] cnt_inc;
  logic       first;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign first       = !in_frame_r;

  always_comb begin
    if (first) begin
      cnt_inc = sdlcfb_pkg::CNT_W'(1);
    end else if (count_r == sdlcfb_pkg::CNT_MAX) begin
      cnt_inc = count_r;
    end else begin
      cnt_inc = count_r + 1'b1;
    end

    q_entry.payload_byte    = in_ch.payload_byte;
    q_entry.station_address = station_address_r;
    q_entry.control_byte    = control_byte_r;
    q_entry.first           = first;
    q_entry.last            = in_ch.last_byte;
    q_entry.overlength      = in_ch.last_byte && (cnt_inc > sdlcfb_pkg::OVL_LIMIT);

    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    if (q_push) begin
      in_frame_nxt = !in_ch.last_byte;
      count_nxt    = in_ch.last_byte ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_address_r <= sdlcfb_pkg::ADDR_RESET;
      control_byte_r    <= sdlcfb_pkg::CTRL_RESET;
      in_frame_r        <= 1'b0;
      count_r           <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          sdlcfb_pkg::CFG_STATION_ADDRESS: station_address_r <= cfg_wdata;
          sdlcfb_pkg::CFG_CONTROL_BYTE:    control_byte_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/sdlcfb_back.sv
// Back part: expands queued items into frame bytes and computes the CRC trailer.
module sdlcfb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sdlcfb_pkg::entry_t  head,
  input  logic                head_valid,
  output logic                pop,
  sdlcfb_out_if.source        out_ch
);

  typedef enum logic [4:0] {
    PH_HEAD   = 5'b00001,
    PH_CTRL   = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_FCS_LO = 5'b01000,
    PH_FCS_HI = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_step;
  logic [15:0] crc_r, crc_nxt, crc_step;
  logic        out_v_r;
  logic [7:0]  frame_byte_r;
  logic        eof_r;
  logic        ovl_r;
  logic [7:0]  byte_c;
  logic        eof_c;
  logic        ovl_c;
  logic        pop_c;
  logic        load;

  assign load = head_valid && (!out_v_r || out_ch.ready);

  always_comb begin
    byte_c     = head.payload_byte;
    eof_c      = 1'b0;
    ovl_c      = 1'b0;
    pop_c      = 1'b0;
    phase_step = phase_r;
    crc_step   = crc_r;
    unique case (phase_r)
      PH_HEAD: begin
        if (head.first) begin
          byte_c     = head.station_address;
          crc_step   = sdlcfb_pkg::crc_byte(crc_r, head.station_address);
          phase_step = PH_CTRL;
        end else begin
          crc_step = sdlcfb_pkg::crc_byte(crc_r, head.payload_byte);
          if (head.last) begin
            phase_step = PH_FCS_LO;
          end else begin
            pop_c = 1'b1;
          end
        end
      end
      PH_CTRL: begin
        byte_c     = head.control_byte;
        crc_step   = sdlcfb_pkg::crc_byte(crc_r, head.control_byte);
        phase_step = PH_DATA;
      end
      PH_DATA: begin
        crc_step = sdlcfb_pkg::crc_byte(crc_r, head.payload_byte);
        if (head.last) begin
          phase_step = PH_FCS_LO;
        end else begin
          phase_step = PH_HEAD;
          pop_c      = 1'b1;
        end
      end
      PH_FCS_LO: begin
        byte_c     = ~crc_r[7:0];
        phase_step = PH_FCS_HI;
      end
      PH_FCS_HI: begin
        byte_c     = ~crc_r[15:8];
        eof_c      = 1'b1;
        ovl_c      = head.overlength;
        crc_step   = sdlcfb_pkg::CRC_PRESET;
        phase_step = PH_HEAD;
        pop_c      = 1'b1;
      end
      default: begin
        phase_step = PH_HEAD;
      end
    endcase

    pop       = load && pop_c;
    phase_nxt = load ? phase_step : phase_r;
    crc_nxt   = load ? crc_step : crc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      crc_r   <= sdlcfb_pkg::CRC_PRESET;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte_r <= byte_c;
      eof_r        <= eof_c;
      ovl_r        <= ovl_c;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.frame_byte   = frame_byte_r;
  assign out_ch.end_of_frame = eof_r;
  assign out_ch.overlength   = ovl_r;

`ifndef ASSERT_OFF
  a_preset_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r == PH_FCS_HI) |=> (crc_r == sdlcfb_pkg::CRC_PRESET))
    else $error("CRC not preset after frame close");

  a_ctrl_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r == PH_CTRL) |=> (phase_r == PH_DATA))
    else $error("control byte not followed by payload byte");

  a_ovl_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && ovl_r) |-> eof_r)
    else $error("overlength flagged on a byte that is not the frame end");
`endif

endmodule

// File: test/tb_sdlc_u_frame_builder.sv
// Testbench for the SDLC U-frame builder: random frames checked against a frame predictor.
module tb_sdlc_u_frame_builder;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int RANDOM_ITEMS   = 240;
  localparam int PRINT_LIMIT    = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    logic       ovl;
  } frame_byte_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [sdlcfb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                       cfg_wdata;

  sdlcfb_in_if  in_ch();
  sdlcfb_out_if out_ch();

  sdlc_u_frame_builder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  payload_item_t payload_backlog[$];
  frame_byte_t   frame_bytes_due[$];
  int            payloads_pushed = 0;
  int            payloads_taken  = 0;
  int            bytes_checked   = 0;
  int            mismatch_cnt    = 0;
  int            stall_cycles    = 0;

  logic [7:0]  addr_reg;
  logic [7:0]  ctrl_reg;
  logic [15:0] crc_acc;
  logic        in_frame;
  logic [10:0] pay_cnt;

  int            burst_left;
  int            gap_left;
  payload_item_t next_item;
  payload_item_t taken;
  frame_byte_t   due;
  logic [5:0]    rx_tick;
  logic [15:0]   rdy_pat;
  int            hold_left;
  bit            hold_req = 1'b0;

  function automatic logic [15:0] crc16_x25_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[15:1]} ^ (r[0] ? sdlcfb_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  function automatic void queue_data_byte(logic [7:0] b);
    frame_byte_t fb;
    crc_acc = crc16_x25_step(crc_acc, b);
    fb.data = b;
    fb.eof  = 1'b0;
    fb.ovl  = 1'b0;
    frame_bytes_due.push_back(fb);
  endfunction

  function automatic void predict_frame_bytes(payload_item_t it);
    logic [15:0] fcs;
    frame_byte_t fb;
    if (!in_frame) begin
      crc_acc = sdlcfb_pkg::CRC_PRESET;
      pay_cnt = '0;
      queue_data_byte(addr_reg);
      queue_data_byte(ctrl_reg);
      in_frame = 1'b1;
    end
    queue_data_byte(it.data);
    if (pay_cnt != sdlcfb_pkg::CNT_MAX) begin
      pay_cnt = pay_cnt + 11'd1;
    end
    if (it.last) begin
      fcs = ~crc_acc;
      fb.data = fcs[7:0];
      fb.eof  = 1'b0;
      fb.ovl  = 1'b0;
      frame_bytes_due.push_back(fb);
      fb.data = fcs[15:8];
      fb.eof  = 1'b1;
      fb.ovl  = (pay_cnt > sdlcfb_pkg::OVL_LIMIT);
      frame_bytes_due.push_back(fb);
      crc_acc  = sdlcfb_pkg::CRC_PRESET;
      pay_cnt  = '0;
      in_frame = 1'b0;
    end
  endfunction

  function automatic void push_item(logic [7:0] d, logic l);
    payload_item_t it;
    it.data = d;
    it.last = l;
    payload_backlog.push_back(it);
    payloads_pushed++;
  endfunction

  function automatic int push_frame(int len, bit close);
    for (int i = 0; i < len; i++) begin
      push_item(8'($urandom_range(0, 255)), close && (i == len - 1));
    end
    return len;
  endfunction

  function automatic logic [7:0] pick_cfg_value();
    case ($urandom_range(0, 3))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic write_reg(logic [sdlcfb_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sdlcfb_pkg::CFG_STATION_ADDRESS) begin
      addr_reg = val;
    end else begin
      ctrl_reg = val;
    end
  endtask

  task automatic wait_drained();
    while (payloads_taken != payloads_pushed || frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(string what);
    if (mismatch_cnt < PRINT_LIMIT) begin
      $display("MISMATCH on frame byte %0d: %s", bytes_checked, what);
    end
    mismatch_cnt++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 32);
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (payload_backlog.size() != 0) begin
        next_item = payload_backlog.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= next_item.data;
        in_ch.last_byte    <= next_item.last;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: a rotating ready pattern, reloaded whenever the 6-bit tick counter wraps, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_tick   = '0;
      rdy_pat   = 16'hFFFF;
      hold_left = 0;
    end else begin
      rx_tick = rx_tick + 6'd1;
      if (hold_req && hold_left == 0) begin
        hold_left = $urandom_range(120, 200);
        hold_req  = 1'b0;
      end
      if (rx_tick == 6'd0) begin
        case ($urandom_range(0, 3))
          0: begin
            rdy_pat = 16'hFFFF;
          end
          1: begin
            rdy_pat = 16'($urandom);
          end
          2: begin
            rdy_pat = 16'($urandom) | 16'($urandom);
          end
          default: begin
            rdy_pat = 16'($urandom) & 16'($urandom);
          end
        endcase
        if (rdy_pat == 16'h0000) begin
          rdy_pat = 16'h0001;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        taken.data = in_ch.payload_byte;
        taken.last = in_ch.last_byte;
        predict_frame_bytes(taken);
        payloads_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_ch.frame_byte));
        end else begin
          due = frame_bytes_due.pop_front();
          if (out_ch.frame_byte !== due.data) begin
            report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                      out_ch.frame_byte, due.data));
          end
          if (out_ch.end_of_frame !== due.eof) begin
            report_mismatch($sformatf("end_of_frame %b, expected %b",
                                      out_ch.end_of_frame, due.eof));
          end
          if (out_ch.overlength !== due.ovl) begin
            report_mismatch($sformatf("overlength %b, expected %b",
                                      out_ch.overlength, due.ovl));
          end
        end
        bytes_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int rand_items;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = sdlcfb_pkg::CFG_STATION_ADDRESS;
    cfg_wdata          = 8'h00;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.last_byte    = 1'b0;
    out_ch.ready       = 1'b0;
    addr_reg           = sdlcfb_pkg::ADDR_RESET;
    ctrl_reg           = sdlcfb_pkg::CTRL_RESET;
    crc_acc            = sdlcfb_pkg::CRC_PRESET;
    in_frame           = 1'b0;
    pay_cnt            = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values, single-byte frames at both payload extremes, then a four-byte frame.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h80, 1'b1);
    wait_drained();
    write_reg(sdlcfb_pkg::CFG_STATION_ADDRESS, 8'h00);
    write_reg(sdlcfb_pkg::CFG_CONTROL_BYTE, 8'hFF);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h7F, 1'b1);
    wait_drained();
    write_reg(sdlcfb_pkg::CFG_STATION_ADDRESS, 8'hFF);
    write_reg(sdlcfb_pkg::CFG_CONTROL_BYTE, 8'h00);
    push_item(8'hFE, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    // A register write inside an open frame only affects the following frame.
    push_item(8'h3C, 1'b0);
    push_item(8'hC3, 1'b0);
    wait_drained();
    write_reg(sdlcfb_pkg::CFG_STATION_ADDRESS, 8'h5A);
    write_reg(sdlcfb_pkg::CFG_CONTROL_BYTE, 8'hA5);
    push_item(8'h99, 1'b1);
    push_item(8'h66, 1'b1);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 1) == 1) begin
        write_reg(sdlcfb_pkg::CFG_STATION_ADDRESS, pick_cfg_value());
      end
      if ($urandom_range(0, 1) == 1) begin
        write_reg(sdlcfb_pkg::CFG_CONTROL_BYTE, pick_cfg_value());
      end
      repeat ($urandom_range(1, 8)) begin
        rand_items += push_frame($urandom_range(1, 12), 1'b1);
      end
      if ($urandom_range(0, 2) == 0) begin
        rand_items += push_frame($urandom_range(1, 3), 1'b0);
      end
    end

    // A long receiver hold-off while a burst is offered fills the block.
    wait_drained();
    write_reg(sdlcfb_pkg::CFG_STATION_ADDRESS, pick_cfg_value());
    write_reg(sdlcfb_pkg::CFG_CONTROL_BYTE, pick_cfg_value());
    hold_req = 1'b1;
    void'(push_frame(16, 1'b1));
    void'(push_frame($urandom_range(1, 4), 1'b1));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
